// ----- rtl/core/lac_pkg.sv -----
// lac_pkg: phase codes, lamp mode codes and the result record of the lift
// actuator controller. No dependencies.
package lac_pkg;

   // phase codes
   localparam logic [2:0] PhIdle           = 3'd0;
   localparam logic [2:0] PhUp             = 3'd1;
   localparam logic [2:0] PhDown           = 3'd2;
   localparam logic [2:0] PhRising         = 3'd3;
   localparam logic [2:0] PhLowering       = 3'd4;
   localparam logic [2:0] PhRisingForced   = 3'd5;
   localparam logic [2:0] PhLoweringForced = 3'd6;

   // lamp mode codes
   localparam logic [1:0] LampOff   = 2'd0;
   localparam logic [1:0] LampOn    = 2'd1;
   localparam logic [1:0] LampBlink = 2'd2;
   localparam logic [1:0] LampFast  = 2'd3;

   // register indexes
   localparam logic RegRaiseTime = 1'b0;
   localparam logic RegLowerTime = 1'b1;

   localparam int TimeWidth    = 20;
   localparam int ElapsedWidth = 10;

   // one result as held in the output queue
   typedef struct packed {
      logic       valve_raise;
      logic       valve_lower;
      logic [1:0] up_lamp_mode;
      logic [1:0] down_lamp_mode;
      logic [2:0] phase_now;
   } result_type;

endpackage

// ----- rtl/core/lift_actuator_controller.sv -----
// lift_actuator_controller: phase state machine, countdown timer, register
// port and two-entry output queue. Depends on lac_pkg.
//
//  channel   direction  handshake                      contents
//  req_*     in         req_valid / req_stall          elapsed ms, four button flags
//  rsp_*     out        rsp_valid / rsp_stall          valve drives, lamp modes, phase
//  p*        in/out     psel, penable, pwrite, pready  raise and lower durations
//
// One request per clock while req_stall is low: the phase update is one
// subtract and compare on the 20-bit count, done in the cycle the request is
// accepted, and the result lands in a two-entry output queue the next edge.
// Synchronous reset puts the phase to idle, both lamps on, the durations and
// count to zero and empties the queue. req_stall rises only when both queue
// entries hold results that the receiving side has not taken.
module lift_actuator_controller (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [9:0]              req_elapsed_ms,
   input  logic                    req_up_short_press,
   input  logic                    req_down_short_press,
   input  logic                    req_up_held_long,
   input  logic                    req_down_held_long,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_valve_raise,
   output logic                    rsp_valve_lower,
   output logic [1:0]              rsp_up_lamp_mode,
   output logic [1:0]              rsp_down_lamp_mode,
   output logic [2:0]              rsp_phase_now,
   // register port
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [2:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   import lac_pkg::*;

   logic [TimeWidth-1:0] raise_time_ff;
   logic [TimeWidth-1:0] lower_time_ff;
   logic [2:0]           phase_ff, phase_in;
   logic [TimeWidth-1:0] time_left_ff, time_left_in;
   logic [1:0]           up_lamp_ff, up_lamp_in;
   logic [1:0]           down_lamp_ff, down_lamp_in;

   logic                 req_take;
   logic                 rsp_take;
   logic                 do_enter;
   logic [2:0]           enter_phase;
   logic [TimeWidth-1:0] elapsed_wide;
   logic                 time_done;
   result_type           result_in;

   result_type           queue_ff [2];
   logic                 wr_ptr_ff, rd_ptr_ff;
   logic [1:0]           count_ff;

   // register port
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         raise_time_ff <= '0;
         lower_time_ff <= '0;
      end else if (psel && penable && pwrite && pready) begin
         unique case (paddr[2])
            RegRaiseTime: raise_time_ff <= pwdata[TimeWidth-1:0];
            RegLowerTime: lower_time_ff <= pwdata[TimeWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         RegRaiseTime: prdata = {{(32-TimeWidth){1'b0}}, raise_time_ff};
         RegLowerTime: prdata = {{(32-TimeWidth){1'b0}}, lower_time_ff};
         default:      prdata = '0;
      endcase
   end

   // handshakes
   assign req_stall = (count_ff == 2'd2);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_take  = rsp_valid && !rsp_stall;

   // countdown compare
   assign elapsed_wide = {{(TimeWidth-ElapsedWidth){1'b0}}, req_elapsed_ms};
   assign time_done    = (elapsed_wide >= time_left_ff);

   // phase transition selection
   always_comb begin
      do_enter     = 1'b0;
      enter_phase  = PhIdle;
      time_left_in = time_left_ff;
      unique case (phase_ff)
         PhUp: begin
            priority if (req_down_short_press) begin
               do_enter = 1'b1; enter_phase = PhLowering;
            end else if (req_down_held_long) begin
               do_enter = 1'b1; enter_phase = PhLoweringForced;
            end else if (req_up_held_long) begin
               do_enter = 1'b1; enter_phase = PhRisingForced;
            end
         end
         PhDown: begin
            priority if (req_up_short_press) begin
               do_enter = 1'b1; enter_phase = PhRising;
            end else if (req_up_held_long) begin
               do_enter = 1'b1; enter_phase = PhRisingForced;
            end else if (req_down_held_long) begin
               do_enter = 1'b1; enter_phase = PhLoweringForced;
            end
         end
         PhRising, PhLowering: begin
            if (time_done) begin
               time_left_in = '0;
               do_enter     = 1'b1;
               enter_phase  = (phase_ff == PhRising) ? PhUp : PhDown;
            end else begin
               time_left_in = time_left_ff - elapsed_wide;
               if (req_up_short_press || req_down_short_press) begin
                  do_enter    = 1'b1;
                  enter_phase = PhIdle;
               end
            end
         end
         PhRisingForced: begin
            if (!req_up_held_long) begin
               do_enter = 1'b1; enter_phase = PhIdle;
            end
         end
         PhLoweringForced: begin
            if (!req_down_held_long) begin
               do_enter = 1'b1; enter_phase = PhIdle;
            end
         end
         default: begin
            // idle, and the unused code which behaves as idle
            priority if (req_up_short_press) begin
               do_enter = 1'b1; enter_phase = PhRising;
            end else if (req_down_short_press) begin
               do_enter = 1'b1; enter_phase = PhLowering;
            end else if (req_up_held_long) begin
               do_enter = 1'b1; enter_phase = PhRisingForced;
            end else if (req_down_held_long) begin
               do_enter = 1'b1; enter_phase = PhLoweringForced;
            end else if (phase_ff != PhIdle) begin
               do_enter = 1'b1; enter_phase = PhIdle;
            end
         end
      endcase
   end

   // entry actions: phase and lamps
   always_comb begin
      phase_in     = phase_ff;
      up_lamp_in   = up_lamp_ff;
      down_lamp_in = down_lamp_ff;
      if (do_enter) begin
         phase_in = enter_phase;
         unique case (enter_phase)
            PhRising: begin
               up_lamp_in   = LampBlink;
               down_lamp_in = LampOff;
            end
            PhLowering: begin
               up_lamp_in   = LampOff;
               down_lamp_in = LampBlink;
            end
            PhUp: begin
               up_lamp_in   = LampOn;
               down_lamp_in = LampOff;
            end
            PhDown: begin
               up_lamp_in   = LampOff;
               down_lamp_in = LampOn;
            end
            PhRisingForced:   up_lamp_in   = LampFast;
            PhLoweringForced: down_lamp_in = LampFast;
            default: begin
               up_lamp_in   = LampOn;
               down_lamp_in = LampOn;
            end
         endcase
      end
   end

   // duration load overrides the countdown on entry to a timed move
   logic [TimeWidth-1:0] time_next;
   always_comb begin
      time_next = time_left_in;
      if (do_enter && enter_phase == PhRising)   time_next = raise_time_ff;
      if (do_enter && enter_phase == PhLowering) time_next = lower_time_ff;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PhIdle;
         time_left_ff <= '0;
         up_lamp_ff   <= LampOn;
         down_lamp_ff <= LampOn;
      end else if (req_take) begin
         phase_ff     <= phase_in;
         time_left_ff <= time_next;
         up_lamp_ff   <= up_lamp_in;
         down_lamp_ff <= down_lamp_in;
      end
   end

   // result for the accepted request
   always_comb begin
      result_in.valve_raise    = (phase_in == PhRising) || (phase_in == PhRisingForced);
      result_in.valve_lower    = (phase_in == PhLowering) || (phase_in == PhLoweringForced);
      result_in.up_lamp_mode   = up_lamp_in;
      result_in.down_lamp_mode = down_lamp_in;
      result_in.phase_now      = phase_in;
   end

   // two-entry output queue
   always_ff @(posedge clock) begin
      if (req_take) queue_ff[wr_ptr_ff] <= result_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (req_take) wr_ptr_ff <= ~wr_ptr_ff;
         if (rsp_take) rd_ptr_ff <= ~rd_ptr_ff;
         if (req_take && !rsp_take)      count_ff <= count_ff + 2'd1;
         else if (!req_take && rsp_take) count_ff <= count_ff - 2'd1;
      end
   end

   assign rsp_valve_raise    = queue_ff[rd_ptr_ff].valve_raise;
   assign rsp_valve_lower    = queue_ff[rd_ptr_ff].valve_lower;
   assign rsp_up_lamp_mode   = queue_ff[rd_ptr_ff].up_lamp_mode;
   assign rsp_down_lamp_mode = queue_ff[rd_ptr_ff].down_lamp_mode;
   assign rsp_phase_now      = queue_ff[rd_ptr_ff].phase_now;

   // checks
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("output queue count out of range");

   a_valves_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_valve_raise && rsp_valve_lower))
      else $error("both valves driven");

   a_forced_lamp: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PhRisingForced) |-> (up_lamp_ff == LampFast))
      else $error("rising forced without fast up lamp");

   a_queue_fill: assert property (@(posedge clock) disable iff (reset)
      (req_take && !rsp_take) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("queue count did not follow a push");

endmodule

// ----- verif/tb_lift_actuator_controller.sv -----
// tb_lift_actuator_controller: self-checking testbench for the lift actuator
// controller. Drives tick requests and register writes, predicts every result.
// Depends on lac_pkg and lift_actuator_controller.
`timescale 1ns / 1ps

module tb_lift_actuator_controller;
   import lac_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int ZeroRows   = 19;
   localparam int DirCount   = 29;
   localparam int HoldCycles = 60;

   typedef struct packed {
      logic [ElapsedWidth-1:0] elapsed;
      logic                    up_short;
      logic                    down_short;
      logic                    up_long;
      logic                    down_long;
   } tick_type;

   typedef struct packed {
      tick_type   tick;
      logic       typed;
      result_type want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [ElapsedWidth-1:0] req_elapsed_ms;
   logic        req_up_short_press;
   logic        req_down_short_press;
   logic        req_up_held_long;
   logic        req_down_held_long;
   tick_type    tick_drv = '0;
   logic        drv_typed = 1'b0;
   result_type  drv_want = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_valve_raise;
   logic        rsp_valve_lower;
   logic [1:0]  rsp_up_lamp_mode;
   logic [1:0]  rsp_down_lamp_mode;
   logic [2:0]  rsp_phase_now;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // pacing controls for sender and receiver
   logic no_idle = 1'b0;
   logic hold_go = 1'b0;
   logic hold_done = 1'b0;
   int   rx_wait = 0;

   // predictor state and register copies
   logic [2:0]           ph = PhIdle;
   logic [TimeWidth:0]   count_left = '0;
   logic [1:0]           up_lamp_m = LampOn;
   logic [1:0]           down_lamp_m = LampOn;
   logic [TimeWidth-1:0] raise_ms = '0;
   logic [TimeWidth-1:0] lower_ms = '0;

   result_type pending_results[$];
   int         mismatches = 0;
   int         results_checked = 0;
   int         reg_writes = 0;
   int         cycle_count = 0;
   int         phase_hits[8];
   logic       up_hold = 1'b0;
   logic       down_hold = 1'b0;

   // directed ticks: first block with both durations zero, second with a
   // maximum raise time and a five millisecond lowering
   dir_row_type dir_rows [DirCount] = '{
      // idle stays idle, lamps on after reset
      '{'{10'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, LampOn, LampOn, PhIdle}},
      '{'{10'd0, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b1, '{1'b1, 1'b0, LampBlink, LampOff, PhRising}},
      // zero duration ends on the next tick
      '{'{10'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, LampOn, LampOff, PhUp}},
      // in up, down short wins over both long presses
      '{'{10'd0, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b1, LampOff, LampBlink, PhLowering}},
      // move end is checked ahead of the abort
      '{'{10'd1023, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, LampOff, LampOn, PhDown}},
      // in down, up short wins over both long presses
      '{'{10'd0, 1'b1, 1'b0, 1'b1, 1'b1}, 1'b1, '{1'b1, 1'b0, LampBlink, LampOff, PhRising}},
      '{'{10'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, LampOn, LampOff, PhUp}},
      // in up, down long wins over up long; up lamp keeps its mode
      '{'{10'd0, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b1, LampOn, LampFast, PhLoweringForced}},
      // releasing down long ends the forced move whatever else is pressed
      '{'{10'd0, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0, LampOn, LampOn, PhIdle}},
      // in idle, up long wins over down long
      '{'{10'd0, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b1, '{1'b1, 1'b0, LampFast, LampOn, PhRisingForced}},
      '{'{10'd0, 1'b0, 1'b1, 1'b0, 1'b1}, 1'b1, '{1'b0, 1'b0, LampOn, LampOn, PhIdle}},
      // in idle, down short wins over up long
      '{'{10'd0, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b1, LampOff, LampBlink, PhLowering}},
      '{'{10'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, LampOff, LampOn, PhDown}},
      // in down, up long wins over down long
      '{'{10'd0, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b1, '{1'b1, 1'b0, LampFast, LampOn, PhRisingForced}},
      '{'{10'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, LampOn, LampOn, PhIdle}},
      '{'{10'd0, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b1, '{1'b1, 1'b0, LampBlink, LampOff, PhRising}},
      '{'{10'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, LampOn, LampOff, PhUp}},
      '{'{10'd0, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b1, '{1'b1, 1'b0, LampFast, LampOff, PhRisingForced}},
      '{'{10'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, LampOn, LampOn, PhIdle}},
      // second block: lowering of 5 ms, ended exactly while an abort is pressed
      '{'{10'd0, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b1, LampOff, LampBlink, PhLowering}},
      '{'{10'd4, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{10'd1, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, LampOff, LampOn, PhDown}},
      // in down, down long alone; up lamp keeps its mode
      '{'{10'd0, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b1, '{1'b0, 1'b1, LampOff, LampFast, PhLoweringForced}},
      '{'{10'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, LampOn, LampOn, PhIdle}},
      // longest raise, long presses ignored, then aborted
      '{'{10'd0, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b1, '{1'b1, 1'b0, LampBlink, LampOff, PhRising}},
      '{'{10'd1023, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
      '{'{10'd1023, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, LampOn, LampOn, PhIdle}},
      '{'{10'd0, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b1, '{1'b0, 1'b1, LampOn, LampFast, PhLoweringForced}},
      '{'{10'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, LampOn, LampOn, PhIdle}}
   };

   assign req_elapsed_ms       = tick_drv.elapsed;
   assign req_up_short_press   = tick_drv.up_short;
   assign req_down_short_press = tick_drv.down_short;
   assign req_up_held_long     = tick_drv.up_long;
   assign req_down_held_long   = tick_drv.down_long;

   lift_actuator_controller dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_elapsed_ms       (req_elapsed_ms),
      .req_up_short_press   (req_up_short_press),
      .req_down_short_press (req_down_short_press),
      .req_up_held_long     (req_up_held_long),
      .req_down_held_long   (req_down_held_long),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_valve_raise      (rsp_valve_raise),
      .rsp_valve_lower      (rsp_valve_lower),
      .rsp_up_lamp_mode     (rsp_up_lamp_mode),
      .rsp_down_lamp_mode   (rsp_down_lamp_mode),
      .rsp_phase_now        (rsp_phase_now),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // phase entry: lamps, and the countdown load for timed moves
   function automatic void enter_phase(input logic [2:0] nxt);
      case (nxt)
         PhRising: begin
            up_lamp_m   = LampBlink;
            down_lamp_m = LampOff;
            count_left  = {1'b0, raise_ms};
         end
         PhLowering: begin
            up_lamp_m   = LampOff;
            down_lamp_m = LampBlink;
            count_left  = {1'b0, lower_ms};
         end
         PhUp: begin
            up_lamp_m   = LampOn;
            down_lamp_m = LampOff;
         end
         PhDown: begin
            up_lamp_m   = LampOff;
            down_lamp_m = LampOn;
         end
         PhRisingForced:   up_lamp_m = LampFast;
         PhLoweringForced: down_lamp_m = LampFast;
         default: begin
            nxt         = PhIdle;
            up_lamp_m   = LampOn;
            down_lamp_m = LampOn;
         end
      endcase
      ph = nxt;
   endfunction

   // next phase and outputs for one tick
   function automatic result_type predict_tick(input tick_type t);
      result_type r;
      case (ph)
         PhUp: begin
            if (t.down_short) enter_phase(PhLowering);
            else if (t.down_long) enter_phase(PhLoweringForced);
            else if (t.up_long) enter_phase(PhRisingForced);
         end
         PhDown: begin
            if (t.up_short) enter_phase(PhRising);
            else if (t.up_long) enter_phase(PhRisingForced);
            else if (t.down_long) enter_phase(PhLoweringForced);
         end
         PhRising, PhLowering: begin
            // end of the countdown takes precedence over an abort
            if ({11'd0, t.elapsed} >= count_left) begin
               count_left = '0;
               enter_phase(ph == PhRising ? PhUp : PhDown);
            end else begin
               count_left = count_left - {11'd0, t.elapsed};
               if (t.up_short || t.down_short) enter_phase(PhIdle);
            end
         end
         PhRisingForced: begin
            if (!t.up_long) enter_phase(PhIdle);
         end
         PhLoweringForced: begin
            if (!t.down_long) enter_phase(PhIdle);
         end
         default: begin
            if (ph != PhIdle) enter_phase(PhIdle);
            if (t.up_short) enter_phase(PhRising);
            else if (t.down_short) enter_phase(PhLowering);
            else if (t.up_long) enter_phase(PhRisingForced);
            else if (t.down_long) enter_phase(PhLoweringForced);
         end
      endcase
      r.valve_raise    = (ph == PhRising || ph == PhRisingForced);
      r.valve_lower    = (ph == PhLowering || ph == PhLoweringForced);
      r.up_lamp_mode   = up_lamp_m;
      r.down_lamp_mode = down_lamp_m;
      r.phase_now      = ph;
      return r;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   // request and result monitor
   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            phase_hits[rsp_phase_now]++;
            if (pending_results.size() == 0) begin
               mismatches++;
               $display("%0t: result with none expected, phase_now %0d", $time,
                        rsp_phase_now);
            end else begin
               want = pending_results.pop_front();
               check_field("valve_raise", want.valve_raise, rsp_valve_raise);
               check_field("valve_lower", want.valve_lower, rsp_valve_lower);
               check_field("up_lamp_mode", want.up_lamp_mode, rsp_up_lamp_mode);
               check_field("down_lamp_mode", want.down_lamp_mode, rsp_down_lamp_mode);
               check_field("phase_now", want.phase_now, rsp_phase_now);
            end
         end
         if (req_valid && !req_stall) begin
            want = predict_tick(tick_drv);
            if (drv_typed) want = drv_want;
            pending_results.push_back(want);
         end
      end
   end

   // receiver pacing: random stall after each result, plus the long hold
   always @(posedge clock) begin
      if (reset) begin
         rx_wait = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) rx_wait = no_idle ? 0 : $urandom_range(0, 4);
         else if (rx_wait > 0) rx_wait = rx_wait - 1;
         rsp_stall <= (hold_go && !hold_done) || rx_wait > 0;
      end
   end

   // long receiver hold, counted here once started
   initial begin
      wait (hold_go);
      repeat (HoldCycles) @(posedge clock);
      hold_done <= 1'b1;
   end

   // run time limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_results.size());
         $display("FAIL");
         $finish;
      end
   end

   // offer one request after a random gap, return at the edge it is taken
   task automatic send_tick(input tick_type t, input logic typed, input result_type want);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      tick_drv  <= t;
      drv_typed <= typed;
      drv_want  <= want;
      do @(posedge clock); while (req_stall);
   endtask

   // hold off requests until every expected result is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // register write: setup then access, then back to idle
   task automatic write_reg(input logic idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == RegRaiseTime) raise_ms = value[TimeWidth-1:0];
      else lower_ms = value[TimeWidth-1:0];
      reg_writes++;
      @(posedge clock);
   endtask

   // one random phase: drain, set both durations, then random ticks
   task automatic run_ticks(input logic [31:0] raise_val, input logic [31:0] lower_val,
                            input int count, input logic long_hold);
      tick_type t;
      int       pick;
      wait_drained();
      write_reg(RegRaiseTime, raise_val);
      write_reg(RegLowerTime, lower_val);
      if (long_hold) hold_go <= 1'b1;
      for (int i = 0; i < count; i++) begin
         // stretches with no idling on either side
         no_idle <= ((i / 20) % 3 == 1);
         // long presses persist over several ticks
         if (up_hold) up_hold = ($urandom_range(0, 4) != 0);
         else up_hold = ($urandom_range(0, 11) == 0);
         if (down_hold) down_hold = ($urandom_range(0, 4) != 0);
         else down_hold = ($urandom_range(0, 11) == 0);
         pick = $urandom_range(0, 99);
         case ($urandom_range(0, 7))
            0:       t.elapsed = '0;
            1:       t.elapsed = '1;
            default: t.elapsed = ElapsedWidth'($urandom_range(0, 1023));
         endcase
         t.up_short   = (pick < 12);
         t.down_short = (pick >= 12 && pick < 24);
         t.up_long    = up_hold;
         t.down_long  = down_hold;
         // noise: every flag random
         if (pick >= 90) t = tick_type'(14'($urandom_range(0, 16383)));
         send_tick(t, 1'b0, '0);
      end
   endtask

   // stimulus
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DirCount; i++) begin
         if (i == ZeroRows) begin
            wait_drained();
            write_reg(RegRaiseTime, 32'hFFFF_FFFF);
            write_reg(RegLowerTime, 32'd5);
         end
         send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].want);
      end
      run_ticks($urandom_range(0, 300), $urandom_range(0, 300), 100, 1'b0);
      run_ticks(32'd0, {12'($urandom_range(0, 4095)), 20'hFFFFF}, 80, 1'b1);
      run_ticks($urandom_range(0, 5000), $urandom_range(0, 5000), 100, 1'b0);
      run_ticks($urandom, $urandom, 60, 1'b0);
      run_ticks($urandom_range(0, 2000), $urandom_range(0, 2000), 160, 1'b0);
      wait_drained();
      repeat (10) @(posedge clock);
      $display("%0d results checked over %0d register writes, %0d mismatches",
               results_checked, reg_writes, mismatches);
      $display("by phase: idle %0d up %0d down %0d rising %0d lowering %0d forced %0d/%0d",
               phase_hits[PhIdle], phase_hits[PhUp], phase_hits[PhDown],
               phase_hits[PhRising], phase_hits[PhLowering], phase_hits[PhRisingForced],
               phase_hits[PhLoweringForced]);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
